### hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared definitions for the deadline timer queue
// Operation and result codes, field widths and the structs that pass
// between the sequencer, the slot store and the top level.
// ----------------------------------------------------------------------------
package dtq_pkg;

	// Default number of timer slots.
	localparam int NumTimersDef = 8;

	// At most this many slots fire on one service request.
	localparam int MaxFires = 8;
	localparam int FireCntW = 4;

	// Field widths.
	localparam int OpW = 2;
	localparam int SlotW = 3;
	localparam int DurW = 32;
	localparam int DlW = 33;
	localparam int ResW = 2;

	// Request operations.
	localparam logic [OpW-1:0] OP_SERVICE = 2'd0;
	localparam logic [OpW-1:0] OP_ARM_ONCE = 2'd1;
	localparam logic [OpW-1:0] OP_ARM_PERIODIC = 2'd2;
	localparam logic [OpW-1:0] OP_STOP = 2'd3;

	// Result codes.
	localparam logic [ResW-1:0] RES_NONE = 2'd0;
	localparam logic [ResW-1:0] RES_FIRED = 2'd1;
	localparam logic [ResW-1:0] RES_REJECT = 2'd2;

	// One result item.
	typedef struct packed {
		logic [ResW-1:0]  res;
		logic [SlotW-1:0] slot;
		logic [DlW-1:0]   deadline;
		logic             last;
	} out_item_t;

	// Write request into the slot store.
	typedef struct packed {
		logic            en;
		logic [DlW-1:0]  deadline;
		logic [DurW-1:0] period;
	} mem_wr_t;

endpackage

### hw/rtl/deadline_timer_queue.sv
// Arm or stop: the request goes from idle to the emit state, and its result
// then enters the output register. Service: one slot read per cycle from the
// store; a request runs fires + 1 scans (at most MaxFires), none if exit_requested.
// Throughput: one request at a time; ready again once its last result is pushed.
// Reset: arst_n clears all armed flags, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// deadline_timer_queue: bank of one-shot and periodic timer slots
// Arms, stops and services timer slots; a service request fires up to
// MaxFires expired slots in deadline order, lower slot first on ties.
// ----------------------------------------------------------------------------
module deadline_timer_queue
	import dtq_pkg::*;
#(
	parameter int NUM_TIMERS = NumTimersDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // slot[2:0], duration[34:3], current_time[66:35],
	                              // exit_requested[67], zero fill
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // fired_slot[2:0], fired_deadline[35:3], zero fill
	output logic [1:0]  m_tuser,  // event_res[1:0]
	output logic        m_tlast   // last
);

	localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic            in_accept;
	logic            idle;
	logic            out_free;
	logic            out_push;
	out_item_t       out_item;
	mem_wr_t         wr;
	logic [IdxW-1:0] wr_addr;
	logic            rd_en;
	logic [IdxW-1:0] rd_addr;
	logic [DlW-1:0]  rd_deadline;
	logic [DurW-1:0] rd_period;
	logic            m_tvalid_q;
	out_item_t       m_item_q;

	assign s_tready = idle;
	assign in_accept = s_tvalid && idle;
	assign out_free = !m_tvalid_q || m_tready;

	dtq_seq #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.in_op      (s_tuser),
		.in_slot    (s_tdata[2:0]),
		.in_dur     (s_tdata[34:3]),
		.in_now     (s_tdata[66:35]),
		.in_exit    (s_tdata[67]),
		.idle       (idle),
		.out_free   (out_free),
		.out_push   (out_push),
		.out_item   (out_item),
		.wr         (wr),
		.wr_addr    (wr_addr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_deadline(rd_deadline),
		.rd_period  (rd_period)
	);

	dtq_store #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_store (
		.clk        (clk),
		.wr         (wr),
		.wr_addr    (wr_addr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_deadline(rd_deadline),
		.rd_period  (rd_period)
	);

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= out_push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			m_item_q <= out_item;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0000, m_item_q.deadline, m_item_q.slot};
	assign m_tuser = m_item_q.res;
	assign m_tlast = m_item_q.last;

endmodule

### hw/rtl/dtq_store.sv
// ----------------------------------------------------------------------------
// dtq_store: deadline and period storage for all timer slots
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtq_store
	import dtq_pkg::*;
#(
	parameter int NUM_TIMERS = NumTimersDef,
	localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic            clk,
	input  mem_wr_t         wr,
	input  logic [IdxW-1:0] wr_addr,
	input  logic            rd_en,
	input  logic [IdxW-1:0] rd_addr,
	output logic [DlW-1:0]  rd_deadline,
	output logic [DurW-1:0] rd_period
);

	logic [DlW-1:0]  deadline_mem [NUM_TIMERS];
	logic [DurW-1:0] period_mem [NUM_TIMERS];
	logic [DlW-1:0]  rd_deadline_q;
	logic [DurW-1:0] rd_period_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			deadline_mem[wr_addr] <= wr.deadline;
			period_mem[wr_addr] <= wr.period;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_deadline_q <= deadline_mem[rd_addr];
			rd_period_q <= period_mem[rd_addr];
		end
	end

	assign rd_deadline = rd_deadline_q;
	assign rd_period = rd_period_q;

endmodule

### hw/rtl/dtq_seq.sv
// ----------------------------------------------------------------------------
// dtq_seq: request sequencer with a shared scan compare and deadline adder
// Handles arm and stop requests straight from idle and runs service requests as
// repeated scans over all slots, firing the earliest expired slot per scan.
// ----------------------------------------------------------------------------
module dtq_seq
	import dtq_pkg::*;
#(
	parameter int NUM_TIMERS = NumTimersDef,
	localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_accept,
	input  logic [OpW-1:0]   in_op,
	input  logic [SlotW-1:0] in_slot,
	input  logic [DurW-1:0]  in_dur,
	input  logic [DurW-1:0]  in_now,
	input  logic             in_exit,
	output logic             idle,
	input  logic             out_free,
	output logic             out_push,
	output out_item_t        out_item,
	output mem_wr_t          wr,
	output logic [IdxW-1:0]  wr_addr,
	output logic             rd_en,
	output logic [IdxW-1:0]  rd_addr,
	input  logic [DlW-1:0]   rd_deadline,
	input  logic [DurW-1:0]  rd_period
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

	logic [2:0]          state_q;
	logic [2:0]          emit_next_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [IdxW-1:0]     scan_idx_q;
	logic                issue_q;
	logic                cmp_vld_s1;
	logic [IdxW-1:0]     cmp_idx_s1;
	logic                found_q;
	logic [IdxW-1:0]     best_idx_q;
	logic [DlW-1:0]      best_dl_q;
	logic [DurW-1:0]     best_per_q;
	logic [DurW-1:0]     now_q;
	logic [FireCntW-1:0] fire_cnt_q;
	logic [SlotW-1:0]    pend_slot_q;
	logic [DlW-1:0]      pend_dl_q;
	out_item_t           emit_q;

	logic [IdxW+2:0]     slot_ext;
	logic [IdxW-1:0]     slot_idx;
	logic                slot_ok;
	logic [IdxW+2:0]     best_ext;
	logic [DurW-1:0]     add_a;
	logic [DurW-1:0]     add_b;
	logic [DlW-1:0]      add_sum;
	logic                cand_hit;
	logic                cand_better;
	logic                arm_req;
	logic                zero_period;
	logic [2:0]          after_fire;

	// Slot addressing of the incoming request.
	always_comb begin
		slot_ext = {{IdxW{1'b0}}, in_slot};
		slot_idx = slot_ext[IdxW-1:0];
		slot_ok = (slot_ext < (IdxW+3)'(NUM_TIMERS));
		best_ext = {3'b000, best_idx_q};
		zero_period = (in_op == OP_ARM_PERIODIC) && (in_dur == '0);
		arm_req = in_accept && slot_ok && !zero_period &&
			((in_op == OP_ARM_ONCE) || (in_op == OP_ARM_PERIODIC));
	end

	// Shared deadline adder: request time plus duration when arming,
	// service time plus period when a periodic slot re-arms.
	always_comb begin
		add_a = (state_q == ST_IDLE) ? in_now : now_q;
		add_b = (state_q == ST_IDLE) ? in_dur : best_per_q;
		add_sum = {1'b0, add_a} + {1'b0, add_b};
	end

	// Store writes from arming and from periodic re-arming.
	always_comb begin
		wr.deadline = add_sum;
		if (state_q == ST_IDLE) begin
			wr.en = arm_req;
			wr.period = (in_op == OP_ARM_PERIODIC) ? in_dur : '0;
			wr_addr = slot_idx;
		end else begin
			wr.en = (state_q == ST_DECIDE) && found_q && (best_per_q != '0);
			wr.period = best_per_q;
			wr_addr = best_idx_q;
		end
	end

	// Shared compare: candidate expired and earlier than the best so far.
	always_comb begin
		cand_hit = cmp_vld_s1 && armed_q[cmp_idx_s1] && (rd_deadline <= {1'b0, now_q});
		cand_better = !found_q || (rd_deadline < best_dl_q);
		after_fire = (fire_cnt_q == FireCntW'(MaxFires - 1)) ? ST_FLUSH : ST_SCAN;
	end

	assign rd_en = (state_q == ST_SCAN) && issue_q;
	assign rd_addr = scan_idx_q;
	assign idle = (state_q == ST_IDLE);
	assign out_push = (state_q == ST_EMIT) && out_free;
	assign out_item = emit_q;

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			emit_next_q <= ST_IDLE;
			armed_q <= '0;
			scan_idx_q <= '0;
			issue_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			fire_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						emit_next_q <= ST_IDLE;
						fire_cnt_q <= '0;
						case (in_op)
							OP_SERVICE: begin
								if (!in_exit) begin
									state_q <= ST_SCAN;
									scan_idx_q <= '0;
									issue_q <= 1'b1;
									found_q <= 1'b0;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							default: begin
								state_q <= ST_EMIT;
								if (slot_ok && !zero_period) begin
									armed_q[slot_idx] <= (in_op != OP_STOP);
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue_q;
					if (issue_q) begin
						if (scan_idx_q == LastIdx) begin
							issue_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
					if (cand_hit && cand_better) begin
						found_q <= 1'b1;
					end
					if (cmp_vld_s1 && (cmp_idx_s1 == LastIdx)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (found_q) begin
						if (best_per_q == '0) begin
							armed_q[best_idx_q] <= 1'b0;
						end
						fire_cnt_q <= fire_cnt_q + 1'b1;
						if (fire_cnt_q != '0) begin
							state_q <= ST_EMIT;
							emit_next_q <= after_fire;
						end else begin
							state_q <= after_fire;
						end
						if ((fire_cnt_q == '0) && (after_fire == ST_SCAN)) begin
							scan_idx_q <= '0;
							issue_q <= 1'b1;
							found_q <= 1'b0;
						end
					end else if (fire_cnt_q != '0) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_EMIT;
						emit_next_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_EMIT;
					emit_next_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= emit_next_q;
						if (emit_next_q == ST_SCAN) begin
							scan_idx_q <= '0;
							issue_q <= 1'b1;
							found_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan payload: compare stage index, best candidate and results.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
		if ((state_q == ST_SCAN) && cand_hit && cand_better) begin
			best_idx_q <= cmp_idx_s1;
			best_dl_q <= rd_deadline;
			best_per_q <= rd_period;
		end
		if ((state_q == ST_IDLE) && in_accept) begin
			now_q <= in_now;
			emit_q.res <= zero_period ? RES_REJECT : RES_NONE;
			emit_q.slot <= '0;
			emit_q.deadline <= '0;
			emit_q.last <= 1'b1;
		end
		if (state_q == ST_DECIDE) begin
			if (found_q) begin
				pend_slot_q <= best_ext[SlotW-1:0];
				pend_dl_q <= best_dl_q;
				emit_q.res <= RES_FIRED;
				emit_q.slot <= pend_slot_q;
				emit_q.deadline <= pend_dl_q;
				emit_q.last <= 1'b0;
			end else begin
				emit_q.res <= RES_NONE;
				emit_q.slot <= '0;
				emit_q.deadline <= '0;
				emit_q.last <= 1'b1;
			end
		end
		if (state_q == ST_FLUSH) begin
			emit_q.res <= RES_FIRED;
			emit_q.slot <= pend_slot_q;
			emit_q.deadline <= pend_dl_q;
			emit_q.last <= 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	// The fire count never passes the per-request limit.
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FireCntW'(MaxFires))
		else $error("fire count exceeds limit");

	// A fired result is only sent while a fire is pending.
	a_fired_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && (out_item.res == RES_FIRED)) |-> (fire_cnt_q != '0))
		else $error("fired result without a pending fire");

	// Results other than a fire always close the request.
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && (out_item.res != RES_FIRED)) |-> out_item.last)
		else $error("non-fire result not marked last");

	// The compare of the last slot ends the scan.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && cmp_vld_s1 && (cmp_idx_s1 == LastIdx))
		|=> (state_q == ST_DECIDE))
		else $error("scan did not end after last slot");

	// A request is taken only while the sequencer is idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> (state_q == ST_IDLE))
		else $error("request taken while busy");
`endif

endmodule
